/* hdl/ccsd_pkg.sv */
// shared types, constants and helpers for the channel command stream decoder
// depends on nothing; every other file imports it
package ccsd_pkg;

    localparam int CLASS_W  = 10;
    localparam int METHOD_W = 16;
    localparam int ARG_W    = 32;
    localparam int WORD_W   = 32;
    localparam int OFFSET_W = 12;
    localparam int IMM_W    = 12;
    localparam int MASK_W   = 16;
    localparam int SCMASK_W = 6;
    localparam int COUNT_W  = 16;
    localparam int MODE_W   = 4;
    localparam int BIT_IDX_W = 4;

    // apb side
    localparam int APB_DATA_W  = 32;
    localparam int APB_ADDR_W  = 3;
    localparam int CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] REG_INITIAL_CLASS = 1'b0;

    // queue between decode and output
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [MODE_W-1:0] {
        MODE_SET_CLASS = 4'd0,
        MODE_INCR      = 4'd1,
        MODE_NONINCR   = 4'd2,
        MODE_MASK      = 4'd3,
        MODE_IMMEDIATE = 4'd4
    } mode_t;

    typedef struct packed {
        logic [CLASS_W-1:0]  target_class;
        logic [METHOD_W-1:0] method_number;
        logic [ARG_W-1:0]    argument;
    } wr_item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    // index of the lowest set bit, top index when the mask is empty
    function automatic logic [BIT_IDX_W-1:0] lowest_bit(input logic [MASK_W-1:0] m);
        logic [BIT_IDX_W-1:0] idx;
        idx = BIT_IDX_W'(MASK_W - 1);
        for (int i = MASK_W - 1; i >= 0; i--)
        begin
            if (m[i])
            begin
                idx = BIT_IDX_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

/* hdl/ccsd_if.sv */
// channel interfaces for the decoder: command words in, method writes out
// depends on ccsd_pkg
interface ccsd_cmd_if;
    import ccsd_pkg::*;
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] command_word;

    modport source (output valid, output command_word, input ready);
    modport sink   (input valid, input command_word, output ready);
endinterface

interface ccsd_wr_if;
    import ccsd_pkg::*;
    logic                valid;
    logic                ready;
    logic [CLASS_W-1:0]  target_class;
    logic [METHOD_W-1:0] method_number;
    logic [ARG_W-1:0]    argument;

    modport source (output valid, output target_class, output method_number,
                    output argument, input ready);
    modport sink   (input valid, input target_class, input method_number,
                    input argument, output ready);
endinterface

/* hdl/channel_command_stream_decoder.sv */
// top level of the channel command stream decoder: apb register, front end,
// queue and output stage; depends on ccsd_pkg, ccsd_if, ccsd_front,
// ccsd_queue and ccsd_back
//
//   port    role        carries
//   cmd     sink        command_word (32b header or data)
//   wr      source      target_class (10b), method_number (16b), argument (32b)
//   apb     slave       initial_class at address 0
//
// one command word is taken every cycle while the 4-entry queue has room
// a method write reaches wr by way of the queue and then the output register
// (decode writes it into the queue, then the output register takes it)
// rst_n clears all header state and sets the active class to 0
// a stall on wr fills the queue; cmd.ready drops only when it is full
module channel_command_stream_decoder
    import ccsd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    ccsd_cmd_if.sink              cmd,
    ccsd_wr_if.source             wr,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic               cfg_wr;
    logic               cfg_hit;
    logic [CLASS_W-1:0] initial_class_reg, initial_class_next;

    logic     push;
    logic     pop;
    wr_item_t push_item;
    wr_item_t head_item;
    q_stat_t  q_stat;

    // apb register: writes land at the access phase, no wait states
    assign pready  = 1'b1;
    assign cfg_hit = (paddr[APB_ADDR_W-1:2] == REG_INITIAL_CLASS);
    assign cfg_wr  = psel && penable && pwrite && pready && cfg_hit;
    assign prdata  = cfg_hit ? APB_DATA_W'(initial_class_reg) : '0;

    always_comb
    begin
        initial_class_next = initial_class_reg;
        if (cfg_wr)
        begin
            initial_class_next = pwdata[CLASS_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            initial_class_reg <= '0;
        end
        else
        begin
            initial_class_reg <= initial_class_next;
        end
    end

    // front end decodes headers and builds writes; the written class also
    // loads the active class at once
    ccsd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cfg_wr    (cfg_wr),
        .cfg_class (pwdata[CLASS_W-1:0]),
        .q_stat    (q_stat),
        .push      (push),
        .push_item (push_item)
    );

    // decouples decode from output stalls
    ccsd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head_item (head_item),
        .q_stat    (q_stat)
    );

    // registered output channel
    ccsd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_stat    (q_stat),
        .head_item (head_item),
        .pop       (pop),
        .wr        (wr)
    );

`ifndef NO_ASSERTIONS
    // the front end never writes into a full queue
    assert property (@(posedge clk) disable iff (!rst_n) push |-> !q_stat.full)
        else $error("write pushed into full queue");

    // the output stage never drains an empty queue
    assert property (@(posedge clk) disable iff (!rst_n) pop |-> !q_stat.empty)
        else $error("pop from empty queue");

    // a pop while full frees exactly one slot
    assert property (@(posedge clk) disable iff (!rst_n)
        (q_stat.full && pop && !push) |=> !q_stat.full)
        else $error("queue stayed full after pop");
`endif

endmodule

/* hdl/ccsd_front.sv */
// front end: accepts command words, tracks header state, builds method writes
// depends on ccsd_pkg and ccsd_cmd_if
module ccsd_front
    import ccsd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    ccsd_cmd_if.sink           cmd,
    input  logic               cfg_wr,
    input  logic [CLASS_W-1:0] cfg_class,
    input  q_stat_t            q_stat,
    output logic               push,
    output wr_item_t           push_item
);

    logic [COUNT_W-1:0]  words_left_reg,   words_left_next;
    logic [METHOD_W-1:0] base_method_reg,  base_method_next;
    logic [MASK_W-1:0]   pending_mask_reg, pending_mask_next;
    logic                step_up_reg,      step_up_next;
    logic [CLASS_W-1:0]  active_class_reg, active_class_next;

    logic                accept;
    logic [BIT_IDX_W-1:0] low_idx;
    logic [MODE_W-1:0]   hdr_mode;
    logic [OFFSET_W-1:0] hdr_offset;
    logic [COUNT_W-1:0]  hdr_value;

    assign cmd.ready  = !q_stat.full;
    assign accept     = cmd.valid && cmd.ready;
    assign low_idx    = lowest_bit(pending_mask_reg);
    assign hdr_mode   = cmd.command_word[31:28];
    assign hdr_offset = cmd.command_word[27:16];
    assign hdr_value  = cmd.command_word[15:0];

    always_comb
    begin
        words_left_next   = words_left_reg;
        base_method_next  = base_method_reg;
        pending_mask_next = pending_mask_reg;
        step_up_next      = step_up_reg;
        active_class_next = active_class_reg;
        push              = 1'b0;
        push_item.target_class  = active_class_reg;
        push_item.method_number = base_method_reg;
        push_item.argument      = cmd.command_word;

        if (accept)
        begin
            if (pending_mask_reg != '0)
            begin
                // data word for the lowest pending mask bit
                push = 1'b1;
                push_item.method_number = base_method_reg + METHOD_W'(low_idx);
                pending_mask_next = pending_mask_reg & (pending_mask_reg - 1'b1);
            end
            else if (words_left_reg != '0)
            begin
                push = 1'b1;
                words_left_next = words_left_reg - 1'b1;
                if (step_up_reg)
                begin
                    base_method_next = base_method_reg + 1'b1;
                end
            end
            else
            begin
                case (mode_t'(hdr_mode))
                    MODE_SET_CLASS:
                    begin
                        pending_mask_next = MASK_W'(hdr_value[SCMASK_W-1:0]);
                        base_method_next  = METHOD_W'(hdr_offset);
                        active_class_next = hdr_value[SCMASK_W +: CLASS_W];
                    end
                    MODE_INCR:
                    begin
                        words_left_next  = hdr_value;
                        base_method_next = METHOD_W'(hdr_offset);
                        step_up_next     = 1'b1;
                    end
                    MODE_NONINCR:
                    begin
                        words_left_next  = hdr_value;
                        base_method_next = METHOD_W'(hdr_offset);
                        step_up_next     = 1'b0;
                    end
                    MODE_MASK:
                    begin
                        pending_mask_next = hdr_value;
                        base_method_next  = METHOD_W'(hdr_offset);
                    end
                    MODE_IMMEDIATE:
                    begin
                        push = 1'b1;
                        push_item.method_number = METHOD_W'(hdr_offset);
                        push_item.argument      = ARG_W'(hdr_value[IMM_W-1:0]);
                    end
                    default:
                    begin
                        push = 1'b0;
                    end
                endcase
            end
        end

        if (cfg_wr)
        begin
            active_class_next = cfg_class;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            words_left_reg   <= '0;
            base_method_reg  <= '0;
            pending_mask_reg <= '0;
            step_up_reg      <= 1'b0;
            active_class_reg <= '0;
        end
        else
        begin
            words_left_reg   <= words_left_next;
            base_method_reg  <= base_method_next;
            pending_mask_reg <= pending_mask_next;
            step_up_reg      <= step_up_next;
            active_class_reg <= active_class_next;
        end
    end

endmodule

/* hdl/ccsd_queue.sv */
// short fifo of method writes between the front end and the output stage
// depends on ccsd_pkg
module ccsd_queue
    import ccsd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  wr_item_t push_item,
    input  logic     pop,
    output wr_item_t head_item,
    output q_stat_t  q_stat
);

    wr_item_t            mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg,  count_next;

    assign q_stat.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign q_stat.empty = (count_reg == '0);
    assign head_item    = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

/* hdl/ccsd_back.sv */
// output stage: pulls method writes from the queue into a registered channel
// depends on ccsd_pkg and ccsd_wr_if
module ccsd_back
    import ccsd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  q_stat_t  q_stat,
    input  wr_item_t head_item,
    output logic     pop,
    ccsd_wr_if.source wr
);

    logic     out_valid_reg, out_valid_next;
    wr_item_t out_item_reg;

    // refill whenever the register is empty or being drained
    assign pop = !q_stat.empty && (!out_valid_reg || wr.ready);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (pop)
        begin
            out_valid_next = 1'b1;
        end
        else if (wr.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_item_reg <= head_item;
        end
    end

    assign wr.valid         = out_valid_reg;
    assign wr.target_class  = out_item_reg.target_class;
    assign wr.method_number = out_item_reg.method_number;
    assign wr.argument      = out_item_reg.argument;

endmodule

/* tb/ccsd_tb_pkg.sv */
// method write tracker for the channel command stream decoder testbench
// depends on ccsd_pkg; tb.sv imports it
package ccsd_tb_pkg;
    import ccsd_pkg::*;

    class method_write_tracker;
        logic [CLASS_W-1:0]  start_class;
        logic [CLASS_W-1:0]  cur_class;
        logic [COUNT_W-1:0]  count_left;
        logic [METHOD_W-1:0] base;
        logic [MASK_W-1:0]   mask_left;
        bit                  incrementing;
        wr_item_t            expected_writes[$];
        int                  errors;

        function new();
            start_class  = '0;
            cur_class    = '0;
            count_left   = '0;
            base         = '0;
            mask_left    = '0;
            incrementing = 1'b0;
            errors       = 0;
        endfunction

        // register write reloads the active class at once
        function void load_class(input logic [CLASS_W-1:0] cls);
            start_class = cls;
            cur_class   = cls;
        endfunction

        function int pending();
            return expected_writes.size();
        endfunction

        // decode one accepted command word
        function void note_word(input logic [WORD_W-1:0] w);
            wr_item_t            e;
            logic [BIT_IDX_W-1:0] b;
            logic [METHOD_W-1:0] offset;
            offset = METHOD_W'(w[27:16]);
            e.target_class = cur_class;
            e.argument     = w;
            if (mask_left != '0)
            begin
                b = '0;
                while (!mask_left[b])
                    b++;
                mask_left[b]    = 1'b0;
                e.method_number = base + METHOD_W'(b);
                expected_writes.push_back(e);
            end
            else if (count_left != '0)
            begin
                e.method_number = base;
                expected_writes.push_back(e);
                if (incrementing)
                    base = base + 1'b1;
                count_left = count_left - 1'b1;
            end
            else
            begin
                case (w[31:28])
                    MODE_SET_CLASS:
                    begin
                        mask_left = MASK_W'(w[5:0]);
                        base      = offset;
                        cur_class = w[15:6];
                    end
                    MODE_INCR:
                    begin
                        count_left   = w[15:0];
                        base         = offset;
                        incrementing = 1'b1;
                    end
                    MODE_NONINCR:
                    begin
                        count_left   = w[15:0];
                        base         = offset;
                        incrementing = 1'b0;
                    end
                    MODE_MASK:
                    begin
                        mask_left = w[15:0];
                        base      = offset;
                    end
                    MODE_IMMEDIATE:
                    begin
                        e.method_number = offset;
                        e.argument      = ARG_W'(w[11:0]);
                        expected_writes.push_back(e);
                    end
                    default:
                    begin
                    end
                endcase
            end
        endfunction

        task report(input string what);
            errors++;
            if (errors <= 100)
                $display("ERROR at %0t: %s", $time, what);
        endtask

        task check_write(input logic [CLASS_W-1:0] cls, input logic [METHOD_W-1:0] method,
                         input logic [ARG_W-1:0] arg);
            wr_item_t e;
            if (expected_writes.size() == 0)
            begin
                report($sformatf("unexpected write class %0h method %0h arg %0h",
                                 cls, method, arg));
                return;
            end
            // oldest expectation first
            e = expected_writes[0];
            expected_writes.delete(0);
            if (cls !== e.target_class)
                report($sformatf("target_class %0h, want %0h", cls, e.target_class));
            if (method !== e.method_number)
                report($sformatf("method_number %0h, want %0h", method, e.method_number));
            if (arg !== e.argument)
                report($sformatf("argument %0h, want %0h", arg, e.argument));
        endtask
    endclass

endpackage

/* tb/tb.sv */
// top of the channel command stream decoder testbench: clock, reset, drivers
// depends on ccsd_pkg, ccsd_if, ccsd_tb_pkg and the decoder rtl
module tb;
    import ccsd_pkg::*;
    import ccsd_tb_pkg::*;

    localparam int IDLE_PCT    = 19;
    localparam int PHASE_WORDS = 240;
    localparam int STALL_LIMIT = 5000;
    localparam int DRAIN_WAIT  = 8;
    // initial_class is register 0, byte address 0
    localparam logic [APB_ADDR_W-1:0] CLASS_ADDR = APB_ADDR_W'({REG_INITIAL_CLASS, 2'b00});

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // set during one whole phase: neither side idles then
    bit no_idle     = 1'b0;
    int quiet_cycles = 0;
    int words_sent  = 0;

    method_write_tracker tracker = new();

    ccsd_cmd_if cmd_ch();
    ccsd_wr_if  wr_ch();

    channel_command_stream_decoder i_dut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd_ch),
        .wr      (wr_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // write side stalls at random, driven at the falling edge
    always @(negedge clk)
    begin
        wr_ch.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
    end

    // every accepted method write is checked against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && wr_ch.valid && wr_ch.ready)
            tracker.check_write(wr_ch.target_class, wr_ch.method_number, wr_ch.argument);
    end

    // watchdog: too long without any handshake means the block hung
    always @(posedge clk)
    begin
        if ((cmd_ch.valid && cmd_ch.ready) || (wr_ch.valid && wr_ch.ready) || (psel && penable))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("channel_command_stream_decoder: mismatch");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic logic [WORD_W-1:0] header(input logic [MODE_W-1:0] mode,
                                                 input logic [OFFSET_W-1:0] offset,
                                                 input logic [15:0] value);
        return {mode, offset, value};
    endfunction

    // offer one command word, entered and left at a falling edge
    task automatic send_word(input logic [WORD_W-1:0] w);
        bit accepted;
        while (!no_idle && $urandom_range(99) < IDLE_PCT)
        begin
            cmd_ch.valid <= 1'b0;
            @(negedge clk);
        end
        cmd_ch.valid        <= 1'b1;
        cmd_ch.command_word <= w;
        accepted = 1'b0;
        while (!accepted)
        begin
            @(posedge clk);
            accepted = cmd_ch.ready;
        end
        tracker.note_word(w);
        words_sent++;
        @(negedge clk);
    endtask

    // apb write of initial_class, then read it back
    task automatic write_initial_class(input logic [CLASS_W-1:0] cls);
        logic [APB_DATA_W-1:0] got;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CLASS_ADDR;
        pwdata  <= APB_DATA_W'(cls);
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        tracker.load_class(cls);
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        got = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (got !== APB_DATA_W'(cls))
            tracker.report($sformatf("initial_class reads %0h, want %0h", got, cls));
    endtask

    // let all expected writes drain, then wait for words still in decode
    task automatic wait_idle();
        cmd_ch.valid <= 1'b0;
        while (tracker.pending() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // mostly well-formed header + data runs with random content,
    // some unused modes, raw words and bodies cut short
    task automatic send_random_sequence();
        int                  pick;
        int                  n;
        logic [MODE_W-1:0]   mode;
        logic [OFFSET_W-1:0] offset;
        logic [15:0]         value;
        pick   = $urandom_range(99);
        offset = OFFSET_W'($urandom);
        value  = 16'($urandom);
        if (pick < 8)
        begin
            send_word(header(MODE_W'($urandom_range(15, 5)), offset, value));
            return;
        end
        if (pick < 14)
        begin
            send_word($urandom);
            return;
        end
        mode = MODE_W'($urandom_range(int'(MODE_IMMEDIATE), int'(MODE_SET_CLASS)));
        case (mode)
            MODE_SET_CLASS:
                n = $countones(value[SCMASK_W-1:0]);
            MODE_INCR, MODE_NONINCR:
            begin
                // zero count now and then, the next word is a header again
                value = ($urandom_range(99) < 10) ? 16'd0 : 16'($urandom_range(40, 1));
                n     = value;
            end
            MODE_MASK:
            begin
                if ($urandom_range(99) < 10)
                    value = '0;
                n = $countones(value);
            end
            default:
                n = 0;
        endcase
        // broken run: the next header gets eaten as data
        if (n > 0 && $urandom_range(99) < 8)
            n = $urandom_range(n - 1);
        send_word(header(mode, offset, value));
        repeat (n) send_word($urandom);
    endtask

    initial
    begin
        int                 start;
        logic [CLASS_W-1:0] class_plan [4];

        rst_n               = 1'b0;
        psel                = 1'b0;
        penable             = 1'b0;
        pwrite              = 1'b0;
        paddr               = '0;
        pwdata              = '0;
        cmd_ch.valid        = 1'b0;
        cmd_ch.command_word = '0;
        wr_ch.ready         = 1'b0;
        class_plan[0] = CLASS_W'($urandom);
        class_plan[1] = '0;
        class_plan[2] = '1;
        class_plan[3] = CLASS_W'($urandom);

        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        // directed part under the top class id
        write_initial_class('1);
        // immediate keeps only the low 12 bits of the value
        send_word(32'h4fff_ffff);
        send_word(32'h4000_0000);
        // unused modes give nothing
        send_word(32'h5abc_def0);
        send_word(32'hffff_ffff);
        // set-class: full 6-bit mask, class 1023, top offset, then six data words
        send_word(32'h0fff_ffff);
        send_word(32'hffff_ffff);
        send_word(32'h0000_0000);
        send_word(32'ha5a5_a5a5);
        send_word(32'h5a5a_5a5a);
        send_word(32'h0000_0001);
        send_word(32'h8000_0000);
        // set-class with empty mask and class 0, next word is a header
        send_word(32'h0000_0000);
        // incrementing with zero count
        send_word(header(MODE_INCR, 12'h005, 16'h0000));
        send_word(32'h4001_0001);
        // incrementing run of three
        send_word(header(MODE_INCR, 12'hffe, 16'h0003));
        send_word(32'h1234_5678);
        send_word(32'h9abc_def0);
        send_word(32'h0f0f_0f0f);
        // non-incrementing run of two
        send_word(header(MODE_NONINCR, 12'h777, 16'h0002));
        send_word(32'hdead_beef);
        send_word(32'h7fff_ffff);
        // empty mask, then lowest and highest mask bits
        send_word(header(MODE_MASK, 12'h000, 16'h0000));
        send_word(header(MODE_MASK, 12'h010, 16'h8001));
        send_word(32'h0000_ffff);
        send_word(32'hffff_0000);

        // incrementing run that carries the method number past the 12-bit offset
        wait_idle();
        write_initial_class('0);
        send_word(header(MODE_INCR, 12'hfff, 16'h0003));
        repeat (3) send_word($urandom);

        // random phases, one register setting each, one phase without idling
        for (int p = 0; p < 4; p++)
        begin
            wait_idle();
            write_initial_class(class_plan[p]);
            no_idle = (p == 1);
            start   = words_sent;
            while (words_sent - start < PHASE_WORDS)
                send_random_sequence();
        end
        no_idle = 1'b0;

        wait_idle();
        repeat (DRAIN_WAIT) @(posedge clk);
        if (tracker.errors == 0)
            $display("channel_command_stream_decoder: match");
        else
            $display("channel_command_stream_decoder: mismatch");
        $finish;
    end

endmodule
